@@ src/vnorm_pkg.sv @@
// shared constants for the vector normalize block
package vnorm_pkg;

    // number of lanes on the ports
    localparam int NUM_LANES = 4;
    // result width and fraction bits of a Q1.14 result
    localparam int OUT_BITS = 16;
    localparam int FRAC_SHIFT = 14;
    // quotient bits: results never exceed 2^FRAC_SHIFT
    localparam int QUOT_BITS = FRAC_SHIFT + 1;
    // smallest length used as divisor, in input LSB
    localparam int MIN_LENGTH = 4;

    // configuration register map
    localparam int CC_BITS = 3;
    localparam logic [CC_BITS-1:0] CC_RESET = 3'd4;
    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

endpackage

@@ src/vnorm_isqrt.sv @@
// pipelined floor square root, one root bit per stage, with sideband
module vnorm_isqrt #(
    parameter int SUM_W = 33,
    parameter int ROOT_W = 17,
    parameter int SIDE_W = 68
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int X_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [X_W-1:0]    x_reg    [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stage
            logic              vld_prev;
            logic [X_W-1:0]    x_prev;
            logic [ROOT_W-1:0] root_prev;
            logic [REM_W-1:0]  rem_prev;
            logic [SIDE_W-1:0] side_prev;
            logic [REM_W-1:0]  shifted;
            logic [REM_W-1:0]  trial;
            logic              ge;

            // stage input selection
            if (k == 0) begin : g_first
                assign vld_prev  = in_valid;
                assign x_prev    = X_W'(in_radicand);
                assign root_prev = '0;
                assign rem_prev  = '0;
                assign side_prev = in_side;
            end else begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign x_prev    = x_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            // one restoring root step
            assign shifted = {rem_prev[ROOT_W-1:0], x_prev[X_W-1 -: 2]};
            assign trial   = {root_prev, 2'b01};
            assign ge      = shifted >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= x_prev << 2;
                    root_reg[k] <= {root_prev[ROOT_W-2:0], ge};
                    rem_reg[k]  <= ge ? (shifted - trial) : shifted;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

@@ src/vector_normalize_top.sv @@
// vector normalize top level: magnitude, squares, sum, root, divide
// stages: 4 front stages, one stage per root bit, 15 divide stages,
//   one output register
// throughput: one item per cycle; the whole pipeline holds while a result
//   waits on the output with stall high
// reset: valid bits clear, channel_count returns to 4
module vector_normalize_top #(
    parameter int MAX_CHANNELS = 4,
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vnorm_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [vnorm_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [vnorm_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COMPONENT_BITS-1:0]      comp0,
    input  logic signed [COMPONENT_BITS-1:0]      comp1,
    input  logic signed [COMPONENT_BITS-1:0]      comp2,
    input  logic signed [COMPONENT_BITS-1:0]      comp3,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vnorm_pkg::OUT_BITS-1:0] unit0,
    output logic signed [vnorm_pkg::OUT_BITS-1:0] unit1,
    output logic signed [vnorm_pkg::OUT_BITS-1:0] unit2,
    output logic signed [vnorm_pkg::OUT_BITS-1:0] unit3
);

    localparam int NL = vnorm_pkg::NUM_LANES;
    localparam int C = COMPONENT_BITS;
    localparam int SQ_W = 2 * C;
    localparam int SUM_W = 2 * C + 1;
    localparam int LEN_W = C + 1;
    localparam int QB = vnorm_pkg::QUOT_BITS;
    localparam int OB = vnorm_pkg::OUT_BITS;
    localparam int LANE_W = C + 1;
    localparam int SIDE_W = NL * LANE_W;
    localparam int CCB = vnorm_pkg::CC_BITS;

    // configuration register
    logic [CCB-1:0] cc_reg;
    logic [CCB-1:0] cc_used;

    assign pready = 1'b1;
    assign prdata = vnorm_pkg::PDATA_BITS'(cc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= vnorm_pkg::CC_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == vnorm_pkg::REG_CHANNEL_COUNT)
        begin
            cc_reg <= pwdata[CCB-1:0];
        end
    end

    assign cc_used = (cc_reg > CCB'(MAX_CHANNELS)) ? CCB'(MAX_CHANNELS) : cc_reg;

    // pipeline advance
    logic en;
    logic out_valid_reg;

    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // stage registers of the front end
    logic signed [C-1:0] comp_w [NL];
    logic            v0_reg, v1_reg, v2_reg, v3_reg;
    logic [C-1:0]    mag0_reg [NL];
    logic [C-1:0]    mag1_reg [NL];
    logic [C-1:0]    mag2_reg [NL];
    logic [C-1:0]    mag3_reg [NL];
    logic            neg0_reg [NL];
    logic            neg1_reg [NL];
    logic            neg2_reg [NL];
    logic            neg3_reg [NL];
    logic [SQ_W-1:0] sq_reg   [NL];
    logic [SUM_W-1:0] pair_reg [2];
    logic [SUM_W-1:0] sum_reg;
    logic [SIDE_W-1:0] side_in;

    assign comp_w[0] = comp0;
    assign comp_w[1] = comp1;
    assign comp_w[2] = comp2;
    assign comp_w[3] = comp3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    genvar l;
    generate
        for (l = 0; l < NL; l++) begin : g_front
            logic         lane_on;
            logic [C-1:0] mag_w;

            // magnitude of a used lane, zero otherwise
            assign lane_on = (l < MAX_CHANNELS) && (cc_used > CCB'(l));
            assign mag_w = comp_w[l][C-1] ? C'(-comp_w[l]) : C'(comp_w[l]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    mag0_reg[l] <= lane_on ? mag_w : '0;
                    neg0_reg[l] <= lane_on && comp_w[l][C-1];
                    sq_reg[l]   <= SQ_W'(mag0_reg[l]) * SQ_W'(mag0_reg[l]);
                    mag1_reg[l] <= mag0_reg[l];
                    neg1_reg[l] <= neg0_reg[l];
                    mag2_reg[l] <= mag1_reg[l];
                    neg2_reg[l] <= neg1_reg[l];
                    mag3_reg[l] <= mag2_reg[l];
                    neg3_reg[l] <= neg2_reg[l];
                end
            end

            assign side_in[l*LANE_W +: LANE_W] = {neg3_reg[l], mag3_reg[l]};
        end
    endgenerate

    // sum of squares as a two level tree
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg[0] <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]);
            pair_reg[1] <= SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
            sum_reg     <= pair_reg[0] + pair_reg[1];
        end
    end

    // root pipeline
    logic              root_valid;
    logic [LEN_W-1:0]  root_w;
    logic [SIDE_W-1:0] root_side;

    vnorm_isqrt #(
        .SUM_W (SUM_W),
        .ROOT_W(LEN_W),
        .SIDE_W(SIDE_W)
    ) u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (v3_reg),
        .in_radicand(sum_reg),
        .in_side    (side_in),
        .out_valid  (root_valid),
        .out_root   (root_w),
        .out_side   (root_side)
    );

    // length floored at the minimum
    logic [LEN_W-1:0] len_w;

    assign len_w = (root_w < LEN_W'(vnorm_pkg::MIN_LENGTH))
                   ? LEN_W'(vnorm_pkg::MIN_LENGTH) : root_w;

    // divider pipeline, one quotient bit per stage
    logic             dvld_reg [QB];
    logic [LEN_W-1:0] dlen_reg [QB];

    genvar d;
    generate
        for (d = 0; d < QB; d++) begin : g_dctl
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dvld_reg[d] <= 1'b0;
                end
                else if (en)
                begin
                    dvld_reg[d] <= (d == 0) ? root_valid : dvld_reg[(d == 0) ? 0 : d-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dlen_reg[d] <= (d == 0) ? len_w : dlen_reg[(d == 0) ? 0 : d-1];
                end
            end
        end
    endgenerate

    logic [OB-1:0] unit_reg [NL];

    generate
        for (l = 0; l < NL; l++) begin : g_lane
            logic [LEN_W-1:0] drem_reg [QB];
            logic [QB-1:0]    dq_reg   [QB];
            logic             dneg_reg [QB];
            logic [C-1:0]     lane_mag;
            logic             lane_neg;
            logic [OB-1:0]    q_ext;

            assign lane_mag = root_side[l*LANE_W +: C];
            assign lane_neg = root_side[l*LANE_W + C];

            for (d = 0; d < QB; d++) begin : g_step
                logic [LEN_W-1:0] rem_prev;
                logic [QB-1:0]    q_prev;
                logic             neg_prev;
                logic [LEN_W-1:0] dlen_prev;
                logic             dbit;
                logic [LEN_W:0]   shifted;
                logic             ge;

                // dividend is mag << 14: high part mag >> 1, then mag[0], then zeros
                if (d == 0) begin : g_first
                    assign rem_prev  = LEN_W'(lane_mag >> 1);
                    assign q_prev    = '0;
                    assign neg_prev  = lane_neg;
                    assign dlen_prev = len_w;
                    assign dbit      = lane_mag[0];
                end else begin : g_next
                    assign rem_prev  = drem_reg[d-1];
                    assign q_prev    = dq_reg[d-1];
                    assign neg_prev  = dneg_reg[d-1];
                    assign dlen_prev = dlen_reg[d-1];
                    assign dbit      = 1'b0;
                end

                assign shifted = {rem_prev, dbit};
                assign ge      = shifted >= {1'b0, dlen_prev};

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        drem_reg[d] <= ge ? LEN_W'(shifted - {1'b0, dlen_prev})
                                          : LEN_W'(shifted);
                        dq_reg[d]   <= {q_prev[QB-2:0], ge};
                        dneg_reg[d] <= neg_prev;
                    end
                end
            end

            // sign restore into the output register
            assign q_ext = OB'(dq_reg[QB-1]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    unit_reg[l] <= dneg_reg[QB-1] ? OB'(-q_ext) : q_ext;
                end
            end
        end
    endgenerate

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dvld_reg[QB-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign unit0 = unit_reg[0];
    assign unit1 = unit_reg[1];
    assign unit2 = unit_reg[2];
    assign unit3 = unit_reg[3];

endmodule

@@ src/vnorm_checker.sv @@
// port level checks for the vector normalize block, bound to the top level
module vnorm_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  pready,
    input logic signed [vnorm_pkg::OUT_BITS-1:0] unit0,
    input logic signed [vnorm_pkg::OUT_BITS-1:0] unit1,
    input logic signed [vnorm_pkg::OUT_BITS-1:0] unit2,
    input logic signed [vnorm_pkg::OUT_BITS-1:0] unit3
);

    localparam int signed UNIT_MAX = 16384;

    // a waiting result holds its valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(unit0) && $stable(unit1)
            && $stable(unit2) && $stable(unit3))
        else $error("result changed while stalled");

    // with no result waiting the input is never stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // normalized components stay within unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (unit0 >= -UNIT_MAX && unit0 <= UNIT_MAX
            && unit1 >= -UNIT_MAX && unit1 <= UNIT_MAX
            && unit2 >= -UNIT_MAX && unit2 <= UNIT_MAX
            && unit3 >= -UNIT_MAX && unit3 <= UNIT_MAX))
        else $error("normalized component out of range");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind vector_normalize_top vnorm_checker u_vnorm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pready   (pready),
    .unit0    (unit0),
    .unit1    (unit1),
    .unit2    (unit2),
    .unit3    (unit3)
);

@@ tb/testbench.sv @@
// testbench for vector_normalize_top: scoreboard class, drivers and a fixed-point predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [vnorm_pkg::OUT_BITS-1:0] u0;
        logic signed [vnorm_pkg::OUT_BITS-1:0] u1;
        logic signed [vnorm_pkg::OUT_BITS-1:0] u2;
        logic signed [vnorm_pkg::OUT_BITS-1:0] u3;
    } unit_vec_t;

    // integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] rem, res, b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // expected normalized vector for the current channel count
    function automatic unit_vec_t normalize(input logic [vnorm_pkg::CC_BITS-1:0] cc,
                                            input logic signed [CB-1:0] c [4]);
        logic [63:0] mag [4];
        logic [63:0] sum, len, q;
        logic [vnorm_pkg::OUT_BITS-1:0] r [4];
        int used;
        used = (cc > 4) ? 4 : cc;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = (c[i] < 0) ? 64'(-64'(c[i])) : 64'(c[i]);
            if (i < used) sum = sum + mag[i] * mag[i];
        end
        len = floor_sqrt(sum);
        if (len < vnorm_pkg::MIN_LENGTH) len = vnorm_pkg::MIN_LENGTH;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = 0;
            if (i < used)
            begin
                q = (mag[i] << vnorm_pkg::FRAC_SHIFT) / len;
                r[i] = (c[i] < 0) ? vnorm_pkg::OUT_BITS'(-q) : vnorm_pkg::OUT_BITS'(q);
            end
        end
        return {r[0], r[1], r[2], r[3]};
    endfunction

    class unit_scoreboard;
        unit_vec_t pending[$];
        int errors;
        logic [vnorm_pkg::CC_BITS-1:0] chan_count;

        function void note_item(logic signed [CB-1:0] c [4]);
            pending.push_back(normalize(chan_count, c));
        endfunction

        function void check_result(unit_vec_t got);
            unit_vec_t exp_v;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_v = pending.pop_front();
            if (got != exp_v)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch cc=%0d exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             chan_count, exp_v.u0, exp_v.u1, exp_v.u2, exp_v.u3,
                             got.u0, got.u1, got.u2, got.u3);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [vnorm_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [vnorm_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic [vnorm_pkg::PDATA_BITS-1:0] prdata;
    logic pready;
    logic in_valid = 0, in_stall;
    logic signed [CB-1:0] comp0 = 0, comp1 = 0, comp2 = 0, comp3 = 0;
    logic out_valid, out_stall = 0;
    logic signed [vnorm_pkg::OUT_BITS-1:0] unit0, unit1, unit2, unit3;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;
    unit_scoreboard sb = new();

    vector_normalize_top dut (.*);

    always #2 clk = ~clk;

    // timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall, long hold-off on request, check
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result({unit0, unit1, unit2, unit3});
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // register write through setup and access cycles
    task automatic write_reg(input int v);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= vnorm_pkg::PADDR_BITS'(vnorm_pkg::REG_CHANNEL_COUNT) << 2;
        pwdata <= vnorm_pkg::PDATA_BITS'(vnorm_pkg::CC_BITS'(v));
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.chan_count = vnorm_pkg::CC_BITS'(v);
    endtask

    // offer one item and hold it until accepted; called at a rising edge
    task automatic send_vec(input int a, b, c, d);
        logic signed [CB-1:0] v [4];
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        v = '{CB'(a), CB'(b), CB'(c), CB'(d)};
        in_valid <= 1;
        comp0 <= CB'(a); comp1 <= CB'(b); comp2 <= CB'(c); comp3 <= CB'(d);
        do @(posedge clk); while (in_stall);
        sb.note_item(v);
    endtask

    // stop offering, wait for all results plus pipeline latency
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    function automatic int rnd_comp();
        unique case ($urandom_range(4))
            0: return int'($urandom_range(7)) - 4;
            1: return $urandom_range(1) ? 32767 : -32768;
            default: return int'(CB'($urandom));
        endcase
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
            send_vec(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
    endtask

    initial
    begin
        sb.errors = 0;
        sb.chan_count = vnorm_pkg::CC_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, tiny and zero vectors at reset count
        send_vec(0, 0, 0, 0);
        send_vec(1, 0, 0, 0);
        send_vec(-1, 3, -2, 1);
        send_vec(32767, 32767, 32767, 32767);
        send_vec(-32768, -32768, -32768, -32768);
        send_vec(-32768, 0, 0, 0);
        send_vec(32767, -32768, 1, -1);
        send_vec(4096, 0, 0, 0);
        drain();
        // count zero, one, and the saturating values above four
        write_reg(0);
        send_vec(100, -100, 5, 7);
        drain();
        write_reg(1);
        send_vec(-5, 9, 9, 9);
        send_vec(-32768, 1, 1, 1);
        drain();
        write_reg(7);
        send_vec(3, 4, 0, 0);
        send_vec(-1, -1, -1, -1);
        drain();
        write_reg(5);
        send_vec(1000, -2000, 3000, -4000);
        drain();

        // random phases, walking through channel counts and idle mixes
        send_idle_pct = 35; recv_idle_pct = 85;
        for (int cc = 1; cc <= 4; cc++)
        begin
            write_reg(cc);
            random_phase(145);
            drain();
        end
        // long receiver hold-off while the sender keeps offering
        hold_cycles = 300;
        send_idle_pct = 85; recv_idle_pct = 35;
        for (int cc = 4; cc >= 1; cc--)
        begin
            write_reg(cc);
            random_phase(145);
            drain();
        end
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(2);
        random_phase(150);
        drain();
        write_reg(3);
        hold_cycles = 200;
        random_phase(150);
        drain();
        write_reg(4);
        random_phase(280);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
